// ----- rtl/sdtq_pkg.sv -----
// Shared types and constants for the sorted delay timer queue.
// No dependencies; imported by sdtq_ram-free logic in the top level.
package sdtq_pkg;

  localparam int unsigned WAKE_W      = 32;
  localparam int unsigned ID_W        = 8;
  localparam int unsigned DELAY_W     = 31;
  // Most sleepers that a single tick may release.
  localparam int unsigned MAX_RELEASE = 32;
  localparam int unsigned REL_W       = $clog2(MAX_RELEASE + 1);

  typedef enum logic [1:0] {
    MODE_TICK  = 2'd0,
    MODE_TIME  = 2'd1,
    MODE_DELAY = 2'd2,
    MODE_BAD   = 2'd3
  } mode_e;

  typedef enum logic [1:0] {
    KIND_ACK  = 2'd0,
    KIND_TIME = 2'd1,
    KIND_WAKE = 2'd2,
    KIND_ERR  = 2'd3
  } kind_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_REL,
    ST_INS,
    ST_FIN
  } state_e;

  typedef struct packed {
    logic [WAKE_W-1:0] wake;
    logic [ID_W-1:0]   id;
  } entry_t;

endpackage

// ----- rtl/sorted_delay_timer_queue_unit.sv -----
// Top level of the sorted delay timer queue.
// Depends on sdtq_pkg and sdtq_ram.
//
// Usage: a word is offered on mode_i, task_id_i and delay_ticks_i with start
// held high; it is taken at the rising edge where start is high and busy is
// low. Results come out one per cycle on kind_o, dest_task_o, tick_value_o
// and last_o, each marked by result_strobe_o for exactly one cycle; last_o
// flags the final result of a word. The receiver cannot stall the block.
//
// Timing: a time query or an error result appears in the cycle after the word
// is taken, and the next word may follow at once. A tick's acknowledge waits
// in the pending slot while the front sleeper is read and is sent from the
// release state, then one wakeup per cycle; busy stays high while the release
// state runs (at most MAX_RELEASE sleepers released). A delay request into an
// empty queue is stored in the accepting cycle. Otherwise the insertion walks
// the queue from the tail, moving one entry per cycle through the read and
// write ports of the sleeper memory, while busy stays high. A delay request
// into a full queue returns an error result; other delay requests return none.
//
// The sleepers live in a circular buffer (head, tail, count) in one RAM. At
// reset the tick count and sleeper count clear; no memory sweep is needed
// because only entries between head and tail are ever used.
module sorted_delay_timer_queue_unit
  import sdtq_pkg::*;
#(
  parameter int unsigned QUEUE_DEPTH = 32
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 start,
  output logic                 busy,
  input  logic [1:0]           mode_i,
  input  logic [ID_W-1:0]      task_id_i,
  input  logic [DELAY_W-1:0]   delay_ticks_i,
  output logic                 result_strobe_o,
  output logic [1:0]           kind_o,
  output logic [ID_W-1:0]      dest_task_o,
  output logic [WAKE_W-1:0]    tick_value_o,
  output logic                 last_o
);

  localparam int unsigned PTR_W = $clog2(QUEUE_DEPTH);
  localparam int unsigned CNT_W = $clog2(QUEUE_DEPTH + 1);
  localparam int unsigned ENT_W = $bits(entry_t);

  // Pointer step forward and backward around the circular buffer.
  function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
    return (p == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : p + PTR_W'(1);
  endfunction

  function automatic logic [PTR_W-1:0] ptr_dec(input logic [PTR_W-1:0] p);
    return (p == '0) ? PTR_W'(QUEUE_DEPTH - 1) : p - PTR_W'(1);
  endfunction

  // Control state.
  state_e             state_q, state_d;
  logic [WAKE_W-1:0]  tick_q, tick_d;
  logic [CNT_W-1:0]   count_q, count_d;
  logic [PTR_W-1:0]   head_q, head_d;
  logic [PTR_W-1:0]   tail_q, tail_d;
  logic [REL_W-1:0]   rel_q, rel_d;
  logic               strobe_q, strobe_d;

  // Working and result payload.
  logic [PTR_W-1:0]   idx_q, idx_d;
  logic [CNT_W-1:0]   rem_q, rem_d;
  logic [WAKE_W-1:0]  wake_q, wake_d;
  logic [ID_W-1:0]    nid_q, nid_d;
  kind_e              pend_kind_q, pend_kind_d;
  logic [ID_W-1:0]    pend_id_q, pend_id_d;
  kind_e              kind_q, kind_d;
  logic [ID_W-1:0]    dest_q, dest_d;
  logic               last_q, last_d;

  // Memory port signals.
  logic               ram_we;
  logic [PTR_W-1:0]   ram_waddr;
  entry_t             ram_wdata;
  logic [PTR_W-1:0]   ram_raddr;
  logic [ENT_W-1:0]   ram_rdata_raw;
  entry_t             ram_rdata;

  logic               accept;
  logic [WAKE_W:0]    wake_sum;
  logic [WAKE_W-1:0]  wake_sat;
  logic               due;
  mode_e              mode;
  entry_t             new_entry;

  sdtq_ram #(
    .WIDTH (ENT_W),
    .DEPTH (QUEUE_DEPTH)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata_raw)
  );

  assign ram_rdata = entry_t'(ram_rdata_raw);
  assign busy      = (state_q != ST_IDLE);
  assign accept    = start && !busy;
  assign mode      = mode_e'(mode_i);

  // Wake time saturates at the top of the counter range.
  assign wake_sum  = {1'b0, tick_q} + {{(WAKE_W + 1 - DELAY_W){1'b0}}, delay_ticks_i};
  assign wake_sat  = wake_sum[WAKE_W] ? '1 : wake_sum[WAKE_W-1:0];

  assign new_entry = '{wake: wake_q, id: nid_q};

  // The front sleeper is due when it wakes strictly before the new count.
  assign due = (count_q != '0) && (rel_q < REL_W'(MAX_RELEASE)) &&
               (tick_q > ram_rdata.wake);

  always_comb begin
    state_d     = state_q;
    tick_d      = tick_q;
    count_d     = count_q;
    head_d      = head_q;
    tail_d      = tail_q;
    rel_d       = rel_q;
    strobe_d    = 1'b0;
    idx_d       = idx_q;
    rem_d       = rem_q;
    wake_d      = wake_q;
    nid_d       = nid_q;
    pend_kind_d = pend_kind_q;
    pend_id_d   = pend_id_q;
    kind_d      = kind_q;
    dest_d      = dest_q;
    last_d      = last_q;
    ram_we      = 1'b0;
    ram_waddr   = ptr_inc(idx_q);
    ram_wdata   = new_entry;
    ram_raddr   = head_q;

    unique case (state_q)
      ST_IDLE: begin
        if (accept) begin
          unique case (mode)
            MODE_TICK: begin
              // Read the front sleeper while the acknowledge waits in the
              // pending slot; its last flag depends on that entry.
              tick_d      = tick_q + WAKE_W'(1);
              pend_kind_d = KIND_ACK;
              pend_id_d   = task_id_i;
              rel_d       = '0;
              ram_raddr   = head_q;
              state_d     = ST_REL;
            end
            MODE_TIME: begin
              strobe_d = 1'b1;
              kind_d   = KIND_TIME;
              dest_d   = task_id_i;
              last_d   = 1'b1;
            end
            MODE_DELAY: begin
              if (count_q == CNT_W'(QUEUE_DEPTH)) begin
                strobe_d = 1'b1;
                kind_d   = KIND_ERR;
                dest_d   = task_id_i;
                last_d   = 1'b1;
              end else if (count_q == '0) begin
                ram_we    = 1'b1;
                ram_waddr = tail_q;
                ram_wdata = '{wake: wake_sat, id: task_id_i};
                tail_d    = ptr_inc(tail_q);
                count_d   = count_q + CNT_W'(1);
              end else begin
                // Walk back from the youngest entry.
                wake_d    = wake_sat;
                nid_d     = task_id_i;
                idx_d     = ptr_dec(tail_q);
                rem_d     = count_q;
                ram_raddr = ptr_dec(tail_q);
                state_d   = ST_INS;
              end
            end
            MODE_BAD: begin
              strobe_d = 1'b1;
              kind_d   = KIND_ERR;
              dest_d   = task_id_i;
              last_d   = 1'b1;
            end
            default: begin
              state_d = ST_IDLE;
            end
          endcase
        end
      end

      ST_REL: begin
        // Send the pending word; it is the last one unless the front is due.
        strobe_d = 1'b1;
        kind_d   = pend_kind_q;
        dest_d   = pend_id_q;
        last_d   = !due;
        if (due) begin
          pend_kind_d = KIND_WAKE;
          pend_id_d   = ram_rdata.id;
          head_d      = ptr_inc(head_q);
          count_d     = count_q - CNT_W'(1);
          rel_d       = rel_q + REL_W'(1);
          ram_raddr   = ptr_inc(head_q);
        end else begin
          state_d = ST_IDLE;
        end
      end

      ST_INS: begin
        ram_we    = 1'b1;
        ram_waddr = ptr_inc(idx_q);
        if (ram_rdata.wake > wake_q) begin
          // Later sleeper moves up one slot; equal wake times stay ahead.
          ram_wdata = ram_rdata;
          rem_d     = rem_q - CNT_W'(1);
          if (rem_q == CNT_W'(1)) begin
            state_d = ST_FIN;
          end else begin
            idx_d     = ptr_dec(idx_q);
            ram_raddr = ptr_dec(idx_q);
          end
        end else begin
          ram_wdata = new_entry;
          tail_d    = ptr_inc(tail_q);
          count_d   = count_q + CNT_W'(1);
          state_d   = ST_IDLE;
        end
      end

      ST_FIN: begin
        // Every sleeper wakes later: the new one goes to the front slot.
        ram_we    = 1'b1;
        ram_waddr = idx_q;
        ram_wdata = new_entry;
        tail_d    = ptr_inc(tail_q);
        count_d   = count_q + CNT_W'(1);
        state_d   = ST_IDLE;
      end

      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= ST_IDLE;
      tick_q   <= '0;
      count_q  <= '0;
      head_q   <= '0;
      tail_q   <= '0;
      rel_q    <= '0;
      strobe_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      tick_q   <= tick_d;
      count_q  <= count_d;
      head_q   <= head_d;
      tail_q   <= tail_d;
      rel_q    <= rel_d;
      strobe_q <= strobe_d;
    end
  end

  always_ff @(posedge clk_i) begin
    idx_q       <= idx_d;
    rem_q       <= rem_d;
    wake_q      <= wake_d;
    nid_q       <= nid_d;
    pend_kind_q <= pend_kind_d;
    pend_id_q   <= pend_id_d;
    kind_q      <= kind_d;
    dest_q      <= dest_d;
    last_q      <= last_d;
  end

  assign result_strobe_o = strobe_q;
  assign kind_o          = kind_q;
  assign dest_task_o     = dest_q;
  assign tick_value_o    = tick_q;
  assign last_o          = last_q;

  // Tail must always sit count entries past head, modulo the depth.
  logic [CNT_W:0] ptr_sum;
  logic [CNT_W:0] tail_chk;

  assign ptr_sum  = {{(CNT_W + 1 - PTR_W){1'b0}}, head_q} + {1'b0, count_q};
  assign tail_chk = (ptr_sum >= (CNT_W + 1)'(QUEUE_DEPTH)) ?
                    ptr_sum - (CNT_W + 1)'(QUEUE_DEPTH) : ptr_sum;

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CNT_W'(QUEUE_DEPTH))
    else $error("sleeper count exceeds queue depth");

  a_ptr_consistent: assert property (@(posedge clk_i) disable iff (!rst_ni)
    tail_chk[PTR_W-1:0] == tail_q)
    else $error("head, tail and count disagree");

  a_ins_nonempty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_INS) |-> (rem_q != '0) && (count_q != '0))
    else $error("insertion walk with nothing left to examine");

  a_tick_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && (mode_i == MODE_TICK)) |=> (tick_q == $past(tick_q) + WAKE_W'(1)))
    else $error("tick count did not advance by one");

endmodule

// ----- rtl/sdtq_ram.sv -----
// Generic single-write, single-read synchronous RAM with registered read data.
// No dependencies.
module sdtq_ram #(
  parameter int unsigned WIDTH  = 40,
  parameter int unsigned DEPTH  = 32,
  parameter int unsigned ADDR_W = $clog2(DEPTH)
) (
  input  logic              clk_i,
  input  logic              we_i,
  input  logic [ADDR_W-1:0] waddr_i,
  input  logic [WIDTH-1:0]  wdata_i,
  input  logic [ADDR_W-1:0] raddr_i,
  output logic [WIDTH-1:0]  rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ----- verif/sorted_delay_timer_queue_unit_tb.sv -----
// Self-checking testbench for sorted_delay_timer_queue_unit: directed and random words,
// with every result checked against a cycle-free shadow of the tick counter and sleeper queue.
// Depends on sdtq_pkg and the RTL of the block; nothing else.
module sorted_delay_timer_queue_unit_tb
  import sdtq_pkg::*;
();
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned QDEPTH = 32;

  // One expected result, in the order the block must produce it.
  typedef struct {
    kind_e             kind;
    logic [ID_W-1:0]   dest;
    logic [WAKE_W-1:0] ticks;
    logic              last;
  } reply_t;

  logic                clk_i = 1'b0;
  logic                rst_ni;
  logic                start;
  logic                busy;
  logic [1:0]          mode_i;
  logic [ID_W-1:0]     task_id_i;
  logic [DELAY_W-1:0]  delay_ticks_i;
  logic                result_strobe_o;
  logic [1:0]          kind_o;
  logic [ID_W-1:0]     dest_task_o;
  logic [WAKE_W-1:0]   tick_value_o;
  logic                last_o;

  // Shadow of the block's state: the tick counter and the sleepers sorted by wake time.
  logic [WAKE_W-1:0]   tick_now;
  logic [WAKE_W-1:0]   wake_at    [QDEPTH];
  logic [ID_W-1:0]     sleeper_of [QDEPTH];
  int                  sleepers;

  reply_t              pending_replies[$];
  int                  errors;
  // Chance, in percent, that the sender idles with start low before a word; it may idle repeatedly.
  int                  idle_pct;

  always #5ns clk_i = ~clk_i;

  sorted_delay_timer_queue_unit #(
    .QUEUE_DEPTH(QDEPTH)
  ) u_top (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start          (start),
    .busy           (busy),
    .mode_i         (mode_i),
    .task_id_i      (task_id_i),
    .delay_ticks_i  (delay_ticks_i),
    .result_strobe_o(result_strobe_o),
    .kind_o         (kind_o),
    .dest_task_o    (dest_task_o),
    .tick_value_o   (tick_value_o),
    .last_o         (last_o)
  );

  // Every result carries the tick count as it stands after the word has been applied.
  task automatic push_reply(kind_e kind, logic [ID_W-1:0] dest, logic last);
    reply_t r;
    r.kind  = kind;
    r.dest  = dest;
    r.ticks = tick_now;
    r.last  = last;
    pending_replies.push_back(r);
  endtask

  // Applies one accepted word to the shadow state and queues the results it causes.
  task automatic predict_replies(mode_e mode, logic [ID_W-1:0] id, logic [DELAY_W-1:0] dly);
    int                due;
    int                pos;
    logic [WAKE_W:0]   sum;
    logic [WAKE_W-1:0] wake;
    case (mode)
      MODE_TICK: begin
        // The counter wraps naturally at the width of tick_now.
        tick_now = tick_now + 1'b1;
        // Release from the front every sleeper whose wake time is strictly below the
        // new count, but never more than MAX_RELEASE in one tick.
        due = 0;
        while (due < sleepers && due < MAX_RELEASE && tick_now > wake_at[due]) due++;
        push_reply(KIND_ACK, id, due == 0);
        for (int i = 0; i < due; i++) push_reply(KIND_WAKE, sleeper_of[i], i == due - 1);
        for (int i = due; i < sleepers; i++) begin
          wake_at[i - due]    = wake_at[i];
          sleeper_of[i - due] = sleeper_of[i];
        end
        sleepers -= due;
      end
      MODE_TIME: push_reply(KIND_TIME, id, 1'b1);
      MODE_DELAY: begin
        if (sleepers >= QDEPTH) begin
          push_reply(KIND_ERR, id, 1'b1);
        end else begin
          // The wake time saturates rather than wrapping.
          sum  = {1'b0, tick_now} + {{(WAKE_W + 1 - DELAY_W){1'b0}}, dly};
          wake = sum[WAKE_W] ? {WAKE_W{1'b1}} : sum[WAKE_W-1:0];
          // A new sleeper goes behind every sleeper with the same wake time.
          pos = 0;
          while (pos < sleepers && wake_at[pos] <= wake) pos++;
          for (int i = sleepers; i > pos; i--) begin
            wake_at[i]    = wake_at[i - 1];
            sleeper_of[i] = sleeper_of[i - 1];
          end
          wake_at[pos]    = wake;
          sleeper_of[pos] = id;
          sleepers++;
        end
      end
      default: push_reply(KIND_ERR, id, 1'b1);
    endcase
  endtask

  // Offers one word and returns at the edge that takes it. Start is left high so that a
  // following word can be offered in the same step without lowering it first.
  task automatic send_word(mode_e mode, logic [ID_W-1:0] id, logic [DELAY_W-1:0] dly);
    while ($urandom_range(0, 99) < idle_pct) begin
      start <= 1'b0;
      @(posedge clk_i);
    end
    start         <= 1'b1;
    mode_i        <= mode;
    task_id_i     <= id;
    delay_ticks_i <= dly;
    do @(posedge clk_i); while (busy);
    predict_replies(mode, id, dly);
  endtask

  // Time replies and errors, an acknowledge on an empty queue, and the extremes of the
  // task field. A bad mode carries a full delay field that must be ignored.
  task automatic test_replies_and_errors();
    send_word(MODE_TIME, 8'h00, '0);
    send_word(MODE_BAD, 8'hFF, {DELAY_W{1'b1}});
    send_word(MODE_BAD, 8'h00, '0);
    send_word(MODE_TICK, 8'h00, {DELAY_W{1'b1}});
    send_word(MODE_TICK, 8'hFF, '0);
    send_word(MODE_TIME, 8'h5A, '0);
  endtask

  // A zero delay wakes on the very next tick, since the new count exceeds the wake time.
  task automatic test_zero_delay();
    send_word(MODE_DELAY, 8'h11, '0);
    send_word(MODE_TIME, 8'h22, '0);
    send_word(MODE_TICK, 8'h33, '0);
    send_word(MODE_TICK, 8'h44, '0);
  endtask

  // Sleepers with equal wake times must come out in the order they arrived.
  task automatic test_equal_wake();
    send_word(MODE_DELAY, 8'hA0, 31'd3);
    send_word(MODE_DELAY, 8'hB0, 31'd1);
    send_word(MODE_DELAY, 8'hC0, 31'd3);
    send_word(MODE_DELAY, 8'hD0, 31'd2);
    repeat (4) send_word(MODE_TICK, 8'h01, '0);
  endtask

  // Fill the store with sleepers that are all due together, refuse one more, then release
  // the whole store on a single tick.
  task automatic test_full_store();
    int n;
    n = 0;
    while (sleepers < QDEPTH) begin
      send_word(MODE_DELAY, 8'h80 + n[7:0], '0);
      n++;
    end
    send_word(MODE_DELAY, 8'h7E, 31'd5);
    send_word(MODE_TICK, 8'h7F, '0);
  endtask

  // The longest delay. Wake time saturation and counter wrap lie some 2^31 ticks away and
  // cannot be reached in a run of this length; these sleepers simply stay in the store.
  task automatic test_long_delay();
    send_word(MODE_DELAY, 8'hC3, {DELAY_W{1'b1}});
    send_word(MODE_DELAY, 8'h3C, {DELAY_W{1'b1}});
    send_word(MODE_TICK, 8'h55, '0);
    send_word(MODE_TIME, 8'hAA, '0);
  endtask

  // Mostly ticks and short sleeps so that sleepers keep waking; now and then a full-range
  // delay, a time query or a bad mode. Unused delay fields are random as well.
  task automatic test_random_words(int count, int pct);
    int    r;
    mode_e mode;
    logic [DELAY_W-1:0] dly;
    idle_pct = pct;
    repeat (count) begin
      r = $urandom_range(0, 99);
      if (r < 40) mode = MODE_TICK;
      else if (r < 55) mode = MODE_TIME;
      else if (r < 92) mode = MODE_DELAY;
      else mode = MODE_BAD;
      if (mode == MODE_DELAY && $urandom_range(0, 99) >= 6) dly = DELAY_W'($urandom_range(0, 6));
      else dly = DELAY_W'($urandom);
      send_word(mode, ID_W'($urandom_range(0, 255)), dly);
    end
  endtask

  // Results cannot be held off, so each strobe is checked at the edge that ends it.
  always @(posedge clk_i) begin : check_replies
    reply_t want;
    if (rst_ni === 1'b1 && result_strobe_o === 1'b1) begin
      if (pending_replies.size() == 0) begin
        $error("result with nothing expected: kind %0d dest_task %0d", kind_o, dest_task_o);
        errors++;
      end else begin
        want = pending_replies.pop_front();
        if (kind_o !== want.kind) begin
          $error("kind: expected %0d, got %0d", want.kind, kind_o);
          errors++;
        end
        if (dest_task_o !== want.dest) begin
          $error("dest_task: expected %0d, got %0d", want.dest, dest_task_o);
          errors++;
        end
        if (tick_value_o !== want.ticks) begin
          $error("tick_value: expected %0d, got %0d", want.ticks, tick_value_o);
          errors++;
        end
        if (last_o !== want.last) begin
          $error("last: expected %0d, got %0d", want.last, last_o);
          errors++;
        end
      end
    end
  end

  initial begin
    errors        = 0;
    idle_pct      = 8;
    tick_now      = '0;
    sleepers      = 0;
    rst_ni        <= 1'b0;
    start         <= 1'b0;
    mode_i        <= MODE_TICK;
    task_id_i     <= '0;
    delay_ticks_i <= '0;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_replies_and_errors();
    test_zero_delay();
    test_equal_wake();
    test_full_store();
    test_long_delay();
    // The sender idles rarely, then often, then never.
    test_random_words(22, 8);
    test_random_words(22, 56);
    test_random_words(22, 0);
    start <= 1'b0;

    // A tick can still be releasing sleepers after its word was taken.
    while (pending_replies.size() != 0) @(posedge clk_i);
    repeat (2 * MAX_RELEASE + 8) @(posedge clk_i);
    if (errors == 0 && pending_replies.size() == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

  // Ends a run that hangs; a correct run finishes well within this limit.
  initial begin : watchdog
    #5ms;
    $display("FAIL");
    $finish;
  end

endmodule

// ----- files.f -----
rtl/sdtq_pkg.sv
rtl/sdtq_ram.sv
rtl/sorted_delay_timer_queue_unit.sv
verif/sorted_delay_timer_queue_unit_tb.sv
